>>> rtl/core/aaqi_pkg.sv
// aaqi_pkg: shared types and codes for the averaged adc quadratic inverse unit
// no dependencies
package aaqi_pkg;

    localparam logic [1:0] MODE_MUL  = 2'd0;
    localparam logic [1:0] MODE_DIV  = 2'd1;
    localparam logic [1:0] MODE_SQRT = 2'd2;

    localparam logic [1:0] REG_COEF_A       = 2'd0;
    localparam logic [1:0] REG_COEF_B       = 2'd1;
    localparam logic [1:0] REG_COEF_C       = 2'd2;
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd3;

    localparam int COEF_W  = 32;
    localparam int COUNT_W = 11;

    typedef struct packed {
        logic       start;
        logic [1:0] mode;
    } eng_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

endpackage

>>> rtl/core/aaqi_accum.sv
// aaqi_accum: running sample sum and sample counter with clamped target count
// depends on aaqi_pkg
module aaqi_accum
    import aaqi_pkg::*;
#(
    parameter int ADC_BITS    = 12,
    parameter int MAX_SAMPLES = 1024,
    parameter int CW          = $clog2(MAX_SAMPLES + 1),
    parameter int SW          = ADC_BITS + CW
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [ADC_BITS-1:0] sample,
    input  logic [COUNT_W-1:0]  count_cfg,
    output logic                full,
    output logic [SW-1:0]       sum_total,
    output logic [CW-1:0]       taken_total
);

    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [EW-1:0] NMAX = EW'(MAX_SAMPLES);

    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] taken_reg, taken_next;
    logic [EW-1:0] ncfg, neff;

    always_comb
    begin
        ncfg = EW'(count_cfg);
        if (ncfg == '0)
            neff = EW'(1);
        else if (ncfg > NMAX)
            neff = NMAX;
        else
            neff = ncfg;
        sum_total   = sum_reg + SW'(sample);
        taken_total = taken_reg + CW'(1);
        full        = EW'(taken_total) >= neff;
        sum_next    = sum_reg;
        taken_next  = taken_reg;
        if (take)
        begin
            if (full)
            begin
                sum_next   = '0;
                taken_next = '0;
            end
            else
            begin
                sum_next   = sum_total;
                taken_next = taken_total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            taken_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            taken_reg <= taken_next;
        end
    end

endmodule

>>> rtl/core/aaqi_engine.sv
// aaqi_engine: shared shift and add/subtract unit, one bit or digit per cycle
// multiply, restoring divide and integer square root; depends on aaqi_pkg
module aaqi_engine
    import aaqi_pkg::*;
#(
    parameter int W    = 68,
    parameter int CNTW = $clog2(W + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  eng_ctrl_t       ctrl,
    input  logic [CNTW-1:0] steps,
    input  logic [W-1:0]    op_aux,
    input  logic [W-1:0]    op_sh,
    output eng_stat_t       stat,
    output logic [W-1:0]    res
);

    logic [W-1:0]    acc_reg, acc_next;
    logic [W-1:0]    aux_reg, aux_next;
    logic [W-1:0]    sh_reg, sh_next;
    logic [1:0]      mode_reg, mode_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [W-1:0]    a_in, b_in;
    logic            sub;
    logic [W:0]      sum;
    logic            ge;

    always_comb
    begin
        case (mode_reg)
            MODE_MUL:
            begin
                a_in = acc_reg;
                b_in = aux_reg;
                sub  = 1'b0;
            end
            MODE_DIV:
            begin
                a_in = {acc_reg[W-2:0], sh_reg[W-1]};
                b_in = aux_reg;
                sub  = 1'b1;
            end
            MODE_SQRT:
            begin
                a_in = {acc_reg[W-3:0], sh_reg[W-1:W-2]};
                b_in = {aux_reg[W-3:0], 2'b01};
                sub  = 1'b1;
            end
            default:
            begin
                a_in = acc_reg;
                b_in = '0;
                sub  = 1'b0;
            end
        endcase
        sum = {1'b0, a_in} + {1'b0, sub ? ~b_in : b_in} + {{W{1'b0}}, sub};
        ge  = sum[W];

        acc_next  = acc_reg;
        aux_next  = aux_reg;
        sh_next   = sh_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            acc_next  = '0;
            aux_next  = op_aux;
            sh_next   = op_sh;
            mode_next = ctrl.mode;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (mode_reg)
                MODE_MUL:
                begin
                    if (sh_reg[0])
                        acc_next = sum[W-1:0];
                    sh_next  = sh_reg >> 1;
                    aux_next = aux_reg << 1;
                end
                MODE_DIV:
                begin
                    acc_next = ge ? sum[W-1:0] : a_in;
                    sh_next  = {sh_reg[W-2:0], ge};
                end
                MODE_SQRT:
                begin
                    acc_next = ge ? sum[W-1:0] : a_in;
                    sh_next  = sh_reg << 2;
                    aux_next = {aux_reg[W-2:0], ge};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= MODE_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        aux_reg <= aux_next;
        sh_reg  <= sh_next;
    end

    always_comb
    begin
        stat.busy = busy_reg;
        stat.done = done_reg;
        case (mode_reg)
            MODE_MUL:  res = acc_reg;
            MODE_DIV:  res = sh_reg;
            MODE_SQRT: res = aux_reg;
            default:   res = acc_reg;
        endcase
    end

endmodule

>>> rtl/core/averaged_adc_quadratic_inverse_unit.sv
// averaged_adc_quadratic_inverse_unit: sample averaging and inverse quadratic curve
// depends on aaqi_pkg, aaqi_accum, aaqi_engine
// a non-final sample is only summed; a final sample starts the solve (mean divide,
//   b squared, 4ac, square root, quotient divide), cut short with zero a or a
//   negative discriminant; every step runs on the single shift/add engine,
//   stepping one bit or root digit per cycle
// throughput: one sample per cycle while summing, no sample taken during the solve
// reset: sum, count, coefficients and sample_count (to 1) cleared asynchronously
module averaged_adc_quadratic_inverse_unit
    import aaqi_pkg::*;
#(
    parameter int ADC_BITS    = 12,
    parameter int MAX_SAMPLES = 1024,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ADC_BITS-1:0]           adc_sample,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [COEF_W-1:0]             cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ADC_BITS+FRAC_BITS-1:0] mean_reading,
    output logic signed [COEF_W-1:0]      level_value,
    output logic                          level_valid
);

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int SW   = ADC_BITS + CW;
    localparam int QW   = ADC_BITS + FRAC_BITS;
    localparam int DFW  = ((QW + 1 > COEF_W) ? QW + 1 : COEF_W) + 1;
    localparam int DW0  = ((2 * COEF_W > DFW + COEF_W + 2) ? 2 * COEF_W : DFW + COEF_W + 2) + 1;
    localparam int DW   = DW0 + (DW0 % 2);
    localparam int RW   = DW / 2;
    localparam int NW   = ((COEF_W > RW) ? COEF_W : RW) + 1;
    localparam int W1   = (DW > SW + FRAC_BITS) ? DW : SW + FRAC_BITS;
    localparam int W    = (W1 > NW + FRAC_BITS) ? W1 : NW + FRAC_BITS;
    localparam int CNTW = $clog2(W + 1);
    localparam int QDW  = NW + FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MEAN = 3'd1;
    localparam logic [2:0] S_B2   = 3'd2;
    localparam logic [2:0] S_FT   = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_QDIV = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [COEF_W-1:0]  coef_a_reg, coef_b_reg, coef_c_reg;
    logic [COUNT_W-1:0] sample_count_reg;

    logic [2:0]     state_reg, state_next;
    logic [QW-1:0]  mean_reg, mean_next;
    logic           dneg_reg, dneg_next;
    logic [DFW-1:0] dmag_reg, dmag_next;
    logic [W-1:0]   b2_reg, b2_next;
    logic           neg_reg, neg_next;
    logic [COEF_W-1:0] lvl_reg, lvl_next;
    logic           lvlv_reg, lvlv_next;

    logic                 out_valid_reg, out_valid_next;
    logic [QW-1:0]        omean_reg, omean_next;
    logic [COEF_W-1:0]    olvl_reg, olvl_next;
    logic                 olvlv_reg, olvlv_next;

    logic          take, full;
    logic [SW-1:0] sum_total;
    logic [CW-1:0] taken_total;

    eng_ctrl_t       eng_ctrl;
    eng_stat_t       eng_stat;
    logic [CNTW-1:0] eng_steps;
    logic [W-1:0]    eng_aux, eng_sh, eng_res;

    logic              a_neg, a_zero;
    logic [COEF_W-1:0] mag_a, mag_b;
    logic signed [DFW-1:0] diff;
    logic [W-1:0]      ft;
    logic              d_add;
    logic [W-1:0]      dval;
    logic signed [NW:0] nb, sx, n1, nsel;
    logic [NW-1:0]     nmag;
    logic [QDW-1:0]    q;
    logic              n1_ok;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign take      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg       <= '0;
            coef_b_reg       <= '0;
            coef_c_reg       <= '0;
            sample_count_reg <= COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COEF_A:       coef_a_reg       <= cfg_data;
                REG_COEF_B:       coef_b_reg       <= cfg_data;
                REG_COEF_C:       coef_c_reg       <= cfg_data;
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[COUNT_W-1:0];
                default:          coef_a_reg       <= coef_a_reg;
            endcase
        end
    end

    aaqi_accum #(
        .ADC_BITS    (ADC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW),
        .SW          (SW)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .sample      (adc_sample),
        .count_cfg   (sample_count_reg),
        .full        (full),
        .sum_total   (sum_total),
        .taken_total (taken_total)
    );

    aaqi_engine #(
        .W    (W),
        .CNTW (CNTW)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (eng_ctrl),
        .steps  (eng_steps),
        .op_aux (eng_aux),
        .op_sh  (eng_sh),
        .stat   (eng_stat),
        .res    (eng_res)
    );

    always_comb
    begin
        a_neg  = coef_a_reg[COEF_W-1];
        a_zero = (coef_a_reg == '0);
        mag_a  = a_neg ? (~coef_a_reg + COEF_W'(1)) : coef_a_reg;
        mag_b  = coef_b_reg[COEF_W-1] ? (~coef_b_reg + COEF_W'(1)) : coef_b_reg;
        diff   = DFW'($signed(coef_c_reg)) - DFW'(eng_res[QW-1:0]);
        ft     = eng_res << 2;
        d_add  = (dmag_reg == '0) || (a_neg != dneg_reg);
        dval   = d_add ? (b2_reg + ft) : (b2_reg - ft);
        nb     = -((NW + 1)'($signed(coef_b_reg)));
        sx     = $signed({1'b0, NW'(eng_res[RW-1:0])});
        n1     = nb + sx;
        n1_ok  = (n1 == '0) || ((!n1[NW]) == (!a_neg));
        nsel   = n1_ok ? n1 : (nb - sx);
        nmag   = nsel[NW] ? NW'(-nsel) : NW'(nsel);
        q      = eng_res[QDW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        mean_next  = mean_reg;
        dneg_next  = dneg_reg;
        dmag_next  = dmag_reg;
        b2_next    = b2_reg;
        neg_next   = neg_reg;
        lvl_next   = lvl_reg;
        lvlv_next  = lvlv_reg;
        eng_ctrl.start = 1'b0;
        eng_ctrl.mode  = MODE_MUL;
        eng_steps = '0;
        eng_aux   = '0;
        eng_sh    = '0;
        out_valid_next = out_valid_reg && !out_ready;
        omean_next = omean_reg;
        olvl_next  = olvl_reg;
        olvlv_next = olvlv_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && full)
                begin
                    eng_ctrl.start = 1'b1;
                    eng_ctrl.mode  = MODE_DIV;
                    eng_steps = CNTW'(SW + FRAC_BITS);
                    eng_aux   = W'(taken_total);
                    eng_sh    = W'(sum_total) << (W - SW);
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                if (eng_stat.done)
                begin
                    mean_next = eng_res[QW-1:0];
                    dneg_next = diff[DFW-1];
                    dmag_next = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
                    lvl_next  = '0;
                    lvlv_next = 1'b0;
                    if (a_zero)
                        state_next = S_FIN;
                    else
                    begin
                        eng_ctrl.start = 1'b1;
                        eng_ctrl.mode  = MODE_MUL;
                        eng_steps = CNTW'(COEF_W);
                        eng_aux   = W'(mag_b);
                        eng_sh    = W'(mag_b);
                        state_next = S_B2;
                    end
                end
            end
            S_B2:
            begin
                if (eng_stat.done)
                begin
                    b2_next = eng_res;
                    eng_ctrl.start = 1'b1;
                    eng_ctrl.mode  = MODE_MUL;
                    eng_steps = CNTW'(COEF_W);
                    eng_aux   = W'(dmag_reg);
                    eng_sh    = W'(mag_a);
                    state_next = S_FT;
                end
            end
            S_FT:
            begin
                if (eng_stat.done)
                begin
                    if (!d_add && (b2_reg < ft))
                        state_next = S_FIN;
                    else
                    begin
                        eng_ctrl.start = 1'b1;
                        eng_ctrl.mode  = MODE_SQRT;
                        eng_steps = CNTW'(RW);
                        eng_sh    = dval << (W - DW);
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                if (eng_stat.done)
                begin
                    neg_next = nsel[NW] != a_neg;
                    eng_ctrl.start = 1'b1;
                    eng_ctrl.mode  = MODE_DIV;
                    eng_steps = CNTW'(QDW);
                    eng_aux   = W'({mag_a, 1'b0});
                    eng_sh    = W'(nmag) << (W - NW);
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (eng_stat.done)
                begin
                    lvlv_next = 1'b1;
                    if (neg_reg)
                    begin
                        if (q > QDW'(33'h1_0000_0000 >> 1))
                            lvl_next = {1'b1, {(COEF_W-1){1'b0}}};
                        else
                            lvl_next = ~q[COEF_W-1:0] + COEF_W'(1);
                    end
                    else
                    begin
                        if (q > QDW'({1'b0, {(COEF_W-1){1'b1}}}))
                            lvl_next = {1'b0, {(COEF_W-1){1'b1}}};
                        else
                            lvl_next = q[COEF_W-1:0];
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    omean_next = mean_reg;
                    olvl_next  = lvl_reg;
                    olvlv_next = lvlv_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg  <= mean_next;
        dneg_reg  <= dneg_next;
        dmag_reg  <= dmag_next;
        b2_reg    <= b2_next;
        neg_reg   <= neg_next;
        lvl_reg   <= lvl_next;
        lvlv_reg  <= lvlv_next;
        omean_reg <= omean_next;
        olvl_reg  <= olvl_next;
        olvlv_reg <= olvlv_next;
    end

    assign out_valid    = out_valid_reg;
    assign mean_reading = omean_reg;
    assign level_value  = olvl_reg;
    assign level_valid  = olvlv_reg;

    a_start_idle_engine: assert property (@(posedge clk) disable iff (!rst_n)
        eng_ctrl.start |-> !eng_stat.busy)
        else $error("engine restarted while busy");

    a_done_in_solve: assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.done |-> (state_reg != S_IDLE && state_reg != S_FIN))
        else $error("engine result with no solve step waiting");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside finish step");

    a_busy_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.busy |-> !in_ready)
        else $error("sample request accepted during solve");

endmodule

>>> tb/tb.sv
// tb: self-checking bench for averaged_adc_quadratic_inverse_unit, with a scoreboard
// class that predicts the mean reading and the inverted curve value for each request
// depends on aaqi_pkg and the averaged_adc_quadratic_inverse_unit rtl
module tb;
    import aaqi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [27:0]        mean;
        logic signed [31:0] level;
        logic               found;
    } reading_t;

    class level_scoreboard;
        logic signed [31:0] coef_a, coef_b, coef_c;
        logic [10:0]        sample_count;
        logic [21:0]        sample_sum;
        logic [10:0]        samples_taken;
        reading_t           readings_q[$];
        int                 errors;

        function new();
            coef_a = 0;
            coef_b = 0;
            coef_c = 0;
            sample_count = 1;
            sample_sum = 0;
            samples_taken = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_COEF_A:       coef_a = val;
                REG_COEF_B:       coef_b = val;
                REG_COEF_C:       coef_c = val;
                REG_SAMPLE_COUNT: sample_count = val[10:0];
                default:          ;
            endcase
        endfunction

        function void invert_curve(logic [27:0] mean, output logic signed [31:0] level,
                                   output logic found);
            longint             a, b, s, n1, n;
            logic signed [127:0] aw, bw, diffw, disc;
            logic [127:0]       rem, root, bitv;
            logic [63:0]        mag, dv, q;
            logic               neg;
            level = 0;
            found = 0;
            a = coef_a;
            b = coef_b;
            if (a == 0)
                return;
            aw = a;
            bw = b;
            diffw = longint'(coef_c) - longint'({36'd0, mean});
            disc = bw * bw - aw * diffw * 4;
            if (disc < 0)
                return;
            rem = disc;
            root = 0;
            for (int k = 126; k >= 0; k -= 2)
            begin
                bitv = 128'd1 << k;
                if (rem >= root + bitv)
                begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
            end
            s = root[63:0];
            n1 = -b + s;
            if (n1 == 0 || ((n1 > 0) == (a > 0)))
                n = n1;
            else
                n = -b - s;
            mag = (n < 0 ? -n : n);
            mag = mag << 16;
            dv = 2 * (a < 0 ? -a : a);
            q = mag / dv;
            neg = (n < 0) != (a < 0);
            if (neg)
            begin
                if (q > 64'h8000_0000)
                    q = 64'h8000_0000;
                level = -q[31:0];
            end
            else
            begin
                if (q > 64'h7FFF_FFFF)
                    q = 64'h7FFF_FFFF;
                level = q[31:0];
            end
            found = 1;
        endfunction

        function void note_sample(logic [11:0] smp);
            int       eff;
            reading_t r;
            eff = sample_count;
            if (eff == 0)
                eff = 1;
            if (eff > 1024)
                eff = 1024;
            sample_sum += smp;
            samples_taken++;
            if (samples_taken < eff)
                return;
            r.mean = ({42'd0, sample_sum} << 16) / samples_taken;
            invert_curve(r.mean, r.level, r.found);
            readings_q.push_back(r);
            sample_sum = 0;
            samples_taken = 0;
        endfunction

        function void check_result(logic [27:0] mean, logic signed [31:0] level,
                                   logic found);
            reading_t r;
            if (readings_q.size() == 0)
            begin
                $display("%0t unexpected result mean %h level %h valid %b",
                         $time, mean, level, found);
                errors++;
                return;
            end
            r = readings_q.pop_front();
            if (mean !== r.mean)
            begin
                $display("%0t mean_reading expected %h actual %h", $time, r.mean, mean);
                errors++;
            end
            if (level !== r.level)
            begin
                $display("%0t level_value expected %h actual %h", $time, r.level, level);
                errors++;
            end
            if (found !== r.found)
            begin
                $display("%0t level_valid expected %b actual %b", $time, r.found, found);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [11:0] adc_sample = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_COEF_A;
    logic [31:0] cfg_data = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [27:0] mean_reading;
    logic signed [31:0] level_value;
    logic        level_valid;

    level_scoreboard sb = new();
    bit quiet = 0;
    int hold_left = 0;
    int items_sent = 0;

    averaged_adc_quadratic_inverse_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .adc_sample  (adc_sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mean_reading(mean_reading),
        .level_value (level_value),
        .level_valid (level_valid)
    );

    always #10 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(mean_reading, level_value, level_valid);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                out_ready <= 0;
            end
            else
                out_ready <= 1;
        end
    end

    task automatic send_sample(logic [11:0] smp);
        in_valid <= 1;
        adc_sample <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(smp);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (sb.readings_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic set_curve(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom();
            3:       return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
            4:       return $urandom_range(1, 4095) << 16;
            default: return -($urandom_range(1, 64) << 16);
        endcase
    endfunction

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'hFFF;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    initial
    begin
        int eff, batches;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // zero a after reset
        send_sample(12'd0);
        send_sample(12'hFFF);
        wait_idle();
        // square root curve
        set_curve(32'h0001_0000, 32'd0, 32'd0);
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'd1);
        send_sample(12'h800);
        wait_idle();
        // negative discriminant
        write_reg(REG_COEF_C, 32'h7FFF_FFFF);
        send_sample(12'd100);
        wait_idle();
        set_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(12'hFFF);
        send_sample(12'd0);
        wait_idle();
        // saturation
        set_curve(32'd1, 32'h8000_0000, 32'd0);
        send_sample(12'h800);
        send_sample(12'hFFF);
        wait_idle();
        // positive root negative, other root taken
        set_curve(32'h0001_0000, 32'd200 << 16, 32'd4095 << 16);
        send_sample(12'd0);
        send_sample(12'd1000);
        wait_idle();
        write_reg(REG_SAMPLE_COUNT, 32'd4);
        repeat (4) send_sample(12'hFFF);
        wait_idle();
        write_reg(REG_SAMPLE_COUNT, 32'd0);
        send_sample(12'd7);
        wait_idle();
        // long sum at a clamped count, then the count lowered mid-sum
        write_reg(REG_SAMPLE_COUNT, 32'd2047);
        repeat (300) send_sample(12'hFFF);
        wait_idle();
        write_reg(REG_SAMPLE_COUNT, 32'd1);
        send_sample(pick_sample());
        wait_idle();

        for (int ph = 0; items_sent < 600; ph++)
        begin
            set_curve(pick_coef(), pick_coef(), pick_coef());
            eff = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            write_reg(REG_SAMPLE_COUNT, eff);
            if (eff == 0)
                eff = 1;
            if (ph == 3)
                hold_left = 400;
            if (items_sent > 500)
                quiet = 1;
            batches = $urandom_range(1, 12);
            repeat (batches * eff) send_sample(pick_sample());
            wait_idle();
        end

        if (sb.errors == 0 && sb.readings_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
